// ----- rtl/s20_pkg.sv -----
// Package with shared types, constants and round functions for the Salsa20 keystream cipher.
package s20_pkg;

	localparam logic [31:0] SIGMA0       = 32'h61707865;
	localparam logic [31:0] SIGMA1_LONG  = 32'h3320646e;
	localparam logic [31:0] SIGMA2_LONG  = 32'h79622d32;
	localparam logic [31:0] SIGMA1_SHORT = 32'h3120646e;
	localparam logic [31:0] SIGMA2_SHORT = 32'h79622d36;
	localparam logic [31:0] SIGMA3       = 32'h6b206574;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd7;

	localparam logic [1:0] ROUNDS_8  = 2'd0;
	localparam logic [1:0] ROUNDS_12 = 2'd1;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_FINAL
	} core_state_t;

	// Queue entry from the front part to the back part.
	typedef struct packed {
		logic [31:0] data;
		logic        xor_en;
		logic [3:0]  pos;
		logic        build;
		logic [63:0] counter;
	} job_t;

	function automatic word_t rotl(input word_t v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic block_t qround(input block_t w, input int a, input int b,
		input int c, input int d);
		block_t x;
		x = w;
		x[b] = x[b] ^ rotl(x[a] + x[d], 7);
		x[c] = x[c] ^ rotl(x[b] + x[a], 9);
		x[d] = x[d] ^ rotl(x[c] + x[b], 13);
		x[a] = x[a] ^ rotl(x[d] + x[c], 18);
		qround = x;
	endfunction

	function automatic block_t double_round(input block_t w);
		block_t x;
		x = w;
		x = qround(x, 0, 4, 8, 12);
		x = qround(x, 5, 9, 13, 1);
		x = qround(x, 10, 14, 2, 6);
		x = qround(x, 15, 3, 7, 11);
		x = qround(x, 0, 1, 2, 3);
		x = qround(x, 5, 6, 7, 4);
		x = qround(x, 10, 11, 8, 9);
		x = qround(x, 15, 12, 13, 14);
		double_round = x;
	endfunction

endpackage

// ----- rtl/s20_stream_if.sv -----
// Valid/ready stream interfaces for data items, results and configuration writes.
interface s20_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_in;
	logic        xor_enable;
	modport source (output valid, output data_in, output xor_enable, input ready);
	modport sink (input valid, input data_in, input xor_enable, output ready);
endinterface

interface s20_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_out;
	logic [3:0]  word_position;
	logic        block_end;
	modport source (output valid, output data_out, output word_position, output block_end,
		input ready);
	modport sink (input valid, input data_out, input word_position, input block_end,
		output ready);
endinterface

interface s20_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/s20_front.sv -----
// Front part: accepts items, tracks word position and block counter, and queues jobs.
module s20_front #(
	parameter int DEPTH = s20_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	s20_in_if.sink          in_ch,
	input  logic            reload,
	input  logic [63:0]     start_block,
	output s20_pkg::job_t   job,
	output logic            job_valid,
	input  logic            job_pop
);
	import s20_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t           mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;
	logic [3:0]     cursor_q;
	logic [63:0]    counter_q;
	logic           push;
	job_t           new_job;

	assign in_ch.ready = (cnt_q != PW'(0) + (PW+1)'(DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign job_valid = (cnt_q != '0);
	assign job = mem_q[rd_q];

	always_comb begin
		new_job.data = in_ch.data_in;
		new_job.xor_en = in_ch.xor_enable;
		new_job.pos = cursor_q;
		new_job.build = (cursor_q == 4'd0);
		new_job.counter = counter_q;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			cursor_q <= '0;
			counter_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (job_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(job_pop);
			if (reload) begin
				cursor_q <= '0;
				counter_q <= start_block;
			end else if (push) begin
				cursor_q <= cursor_q + 4'd1;
				if (cursor_q == 4'd0) begin
					counter_q <= counter_q + 64'd1;
				end
			end
		end
	end
endmodule

// ----- rtl/s20_back.sv -----
// Back part: runs the Salsa20 core when a block is needed and delivers keystream words.
module s20_back (
	input  logic            clk,
	input  logic            arst_n,
	input  s20_pkg::job_t   job,
	input  logic            job_valid,
	output logic            job_pop,
	input  logic [255:0]    key,
	input  logic            key_short,
	input  logic [63:0]     nonce,
	input  logic [1:0]      rounds,
	s20_out_if.source       out_ch
);
	import s20_pkg::*;

	core_state_t   state_q, state_d;
	block_t        in_q;
	block_t        x_q;
	block_t        ks_q;
	logic [3:0]    dr_q;
	logic [3:0]    pairs;
	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic [3:0]    out_pos_q;
	logic          start_core;
	logic          deliver;
	logic          out_free;
	block_t        init;
	logic [127:0]  khi;
	block_t        ks_sum;

	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		khi = key_short ? key[127:0] : key[255:128];
		init[0] = SIGMA0;
		init[1] = key[31:0];
		init[2] = key[63:32];
		init[3] = key[95:64];
		init[4] = key[127:96];
		init[5] = key_short ? SIGMA1_SHORT : SIGMA1_LONG;
		init[6] = nonce[31:0];
		init[7] = nonce[63:32];
		init[8] = job.counter[31:0];
		init[9] = job.counter[63:32];
		init[10] = key_short ? SIGMA2_SHORT : SIGMA2_LONG;
		init[11] = khi[31:0];
		init[12] = khi[63:32];
		init[13] = khi[95:64];
		init[14] = khi[127:96];
		init[15] = SIGMA3;
		case (rounds)
			ROUNDS_8: pairs = 4'd4;
			ROUNDS_12: pairs = 4'd6;
			default: pairs = 4'd10;
		endcase
		for (int i = 0; i < 16; i++) begin
			ks_sum[i] = x_q[i] + in_q[i];
		end
	end

	always_comb begin
		state_d = state_q;
		start_core = 1'b0;
		deliver = 1'b0;
		case (state_q)
			CORE_IDLE: begin
				if (job_valid) begin
					if (job.build) begin
						start_core = 1'b1;
						state_d = CORE_ROUND;
					end else if (out_free) begin
						deliver = 1'b1;
					end
				end
			end
			CORE_ROUND: begin
				if (dr_q == 4'd1) begin
					state_d = CORE_FINAL;
				end
			end
			CORE_FINAL: begin
				if (out_free) begin
					deliver = 1'b1;
					state_d = CORE_IDLE;
				end
			end
			default: state_d = CORE_IDLE;
		endcase
	end

	assign job_pop = deliver;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
			dr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_core) begin
				dr_q <= pairs;
			end else if (state_q == CORE_ROUND) begin
				dr_q <= dr_q - 4'd1;
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_core) begin
			in_q <= init;
			x_q <= init;
		end else if (state_q == CORE_ROUND) begin
			x_q <= double_round(x_q);
		end
		if (state_q == CORE_FINAL && deliver) begin
			ks_q <= ks_sum;
		end
		if (deliver) begin
			out_data_q <= ((state_q == CORE_FINAL) ? ks_sum[job.pos] : ks_q[job.pos])
				^ (job.xor_en ? job.data : 32'd0);
			out_pos_q <= job.pos;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data_out = out_data_q;
	assign out_ch.word_position = out_pos_q;
	assign out_ch.block_end = (out_pos_q == 4'd15);
endmodule

// ----- rtl/salsa20_keystream_cipher.sv -----
// Top level of the Salsa20 keystream cipher with configuration registers.
// Usage: data words enter on in_ch (data_in, xor_enable) and leave on out_ch
// as data_out, word_position and block_end, one result for each transfer in.
// Configuration writes arrive on cfg_ch (index, data) and are taken at once;
// they must only be made while no item is in flight.
// A front stage numbers each word and captures the block counter, then
// places it in a two-entry queue. The back stage runs one double round per
// cycle whenever word 0 of a block arrives: that word passes the selected
// number of double rounds (4, 6 or 10) and then the final state, where it
// waits for out_ch, before its result is registered; each of the other
// fifteen words is taken from the queue head into the result register, so
// they can follow one per cycle while out_ch does not stall.
// When out_ch stalls, the result register holds and the queue fills, after
// which in_ch drops ready. Reset empties the queue, clears the word position
// and loads the block counter with zero; registers take their reset values.
module salsa20_keystream_cipher #(
	parameter int QUEUE_DEPTH = s20_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	s20_in_if.sink     in_ch,
	s20_out_if.source  out_ch,
	s20_cfg_if.sink    cfg_ch
);
	import s20_pkg::*;

	logic [255:0]  key_q;
	logic          short_q;
	logic [63:0]   nonce_q;
	logic [63:0]   start_q;
	logic [1:0]    rounds_q;
	logic          cfg_wr;
	logic          reload;
	job_t          job;
	logic          job_valid;
	logic          job_pop;

	assign cfg_ch.ready = 1'b1;
	assign cfg_wr = cfg_ch.valid;
	assign reload = cfg_wr && (cfg_ch.index != REG_ROUNDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			short_q <= 1'b0;
			nonce_q <= '0;
			start_q <= '0;
			rounds_q <= 2'd2;
		end else if (cfg_wr) begin
			case (cfg_ch.index)
				REG_KEY0: key_q[63:0] <= cfg_ch.data;
				REG_KEY1: key_q[127:64] <= cfg_ch.data;
				REG_KEY2: key_q[191:128] <= cfg_ch.data;
				REG_KEY3: key_q[255:192] <= cfg_ch.data;
				REG_SHORT: short_q <= cfg_ch.data[0];
				REG_NONCE: nonce_q <= cfg_ch.data;
				REG_START: start_q <= cfg_ch.data;
				REG_ROUNDS: rounds_q <= cfg_ch.data[1:0];
				default: ;
			endcase
		end
	end

	s20_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.reload     (reload),
		.start_block((cfg_ch.index == REG_START) ? cfg_ch.data : start_q),
		.job        (job),
		.job_valid  (job_valid),
		.job_pop    (job_pop)
	);

	s20_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.key      (key_q),
		.key_short(short_q),
		.nonce    (nonce_q),
		.rounds   (rounds_q),
		.out_ch   (out_ch)
	);

`ifndef SYNTHESIS
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("queue popped while empty");
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> out_ch.valid) else $error("delivered job produced no result");
	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.block_end |-> out_ch.word_position == 4'd15)
		else $error("block end flag on wrong word");
`endif
endmodule

// ----- test/tb_salsa20_keystream_cipher.sv -----
// Testbench for the Salsa20 keystream cipher: predicted keystream words checked transfer by transfer.
`timescale 1ns / 100ps
module tb_salsa20_keystream_cipher;
	import s20_pkg::*;

	typedef struct {
		logic [31:0] data;
		logic [3:0]  pos;
		logic        last;
	} ks_result_t;

	class keystream_board;
		logic [63:0] key [4];
		logic        short_key;
		logic [63:0] nonce;
		logic [63:0] start_ctr;
		logic [1:0]  rounds;
		logic [63:0] counter;
		logic [31:0] words [16];
		logic [3:0]  cursor;
		ks_result_t  pending [$];
		int          errors;

		function void set_defaults();
			foreach (key[i]) key[i] = '0;
			short_key = 0;
			nonce = '0;
			start_ctr = '0;
			rounds = 2'd2;
			counter = '0;
			cursor = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key[idx] = val;
				REG_SHORT: short_key = val[0];
				REG_NONCE: nonce = val;
				REG_START: start_ctr = val;
				default: ;
			endcase
			if (idx == REG_ROUNDS) rounds = val[1:0];
			else begin
				counter = start_ctr;
				cursor = '0;
			end
		endfunction

		function logic [31:0] rol(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void quarter(ref logic [31:0] x [16], input int a, int b, int c, int d);
			x[b] ^= rol(x[a] + x[d], 7);
			x[c] ^= rol(x[b] + x[a], 9);
			x[d] ^= rol(x[c] + x[b], 13);
			x[a] ^= rol(x[d] + x[c], 18);
		endfunction

		function void make_block();
			logic [31:0] st [16];
			logic [31:0] x [16];
			logic [63:0] k2, k3;
			int n;
			k2 = short_key ? key[0] : key[2];
			k3 = short_key ? key[1] : key[3];
			st = '{SIGMA0, key[0][31:0], key[0][63:32], key[1][31:0], key[1][63:32],
				short_key ? SIGMA1_SHORT : SIGMA1_LONG, nonce[31:0], nonce[63:32],
				counter[31:0], counter[63:32], short_key ? SIGMA2_SHORT : SIGMA2_LONG,
				k2[31:0], k2[63:32], k3[31:0], k3[63:32], SIGMA3};
			x = st;
			n = (rounds == ROUNDS_8) ? 4 : (rounds == ROUNDS_12) ? 6 : 10;
			for (int i = 0; i < n; i++) begin
				quarter(x, 0, 4, 8, 12);
				quarter(x, 5, 9, 13, 1);
				quarter(x, 10, 14, 2, 6);
				quarter(x, 15, 3, 7, 11);
				quarter(x, 0, 1, 2, 3);
				quarter(x, 5, 6, 7, 4);
				quarter(x, 10, 11, 8, 9);
				quarter(x, 15, 12, 13, 14);
			end
			for (int i = 0; i < 16; i++) words[i] = x[i] + st[i];
			counter++;
		endfunction

		function void note_input(logic [31:0] d, logic xe);
			ks_result_t r;
			if (cursor == 0) make_block();
			r.data = xe ? words[cursor] ^ d : words[cursor];
			r.pos = cursor;
			r.last = (cursor == 4'd15);
			pending.push_back(r);
			cursor++;
		endfunction

		task fail(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_output(logic [31:0] d, logic [3:0] p, logic e);
			ks_result_t r;
			if (pending.size() == 0) begin
				fail("result with nothing expected");
				return;
			end
			r = pending.pop_front();
			if (d !== r.data) fail($sformatf("data_out %h, want %h", d, r.data));
			if (p !== r.pos) fail($sformatf("word_position %0d, want %0d", p, r.pos));
			if (e !== r.last) fail($sformatf("block_end %b, want %b", e, r.last));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	s20_in_if  in_ch ();
	s20_out_if out_ch ();
	s20_cfg_if cfg_ch ();
	keystream_board board;
	int src_idle, sink_stall, quiet;

	salsa20_keystream_cipher dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .cfg_ch(cfg_ch));

	initial forever #5 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data_in = '0;
		in_ch.xor_enable = 0;
		out_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
	end

	always @(posedge clk) begin
		if (arst_n) out_ch.ready <= ($urandom_range(99) >= sink_stall);
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_output(out_ch.data_out, out_ch.word_position, out_ch.block_end);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("tb_salsa20_keystream_cipher: FAIL");
			$finish;
		end
	end

	task automatic send_word(logic [31:0] d, logic xe);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data_in <= d;
		in_ch.xor_enable <= xe;
		do @(posedge clk); while (!in_ch.ready);
		board.note_input(d, xe);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		board.write_reg(idx, val);
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic setup_random();
		for (int i = 0; i < 4; i++) write_cfg(i[2:0], rand64());
		write_cfg(REG_SHORT, 64'($urandom_range(1)));
		write_cfg(REG_NONCE, rand64());
		write_cfg(REG_START, $urandom_range(3) == 0 ? 64'hFFFF_FFFF_FFFF_FFFE : rand64());
		write_cfg(REG_ROUNDS, 64'($urandom_range(3)));
	endtask

	initial begin
		board = new();
		board.set_defaults();
		src_idle = 0;
		sink_stall = 0;
		quiet = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed part: reset defaults, extremes including an all-ones block counter, short key.
		send_word('0, 1'b0);
		send_word('1, 1'b1);
		for (int i = 0; i < 14; i++) send_word($urandom(), 1'(i % 2));
		send_word(32'hA5A5_5A5A, 1'b1);
		drain();
		write_cfg(REG_KEY0, '1);
		write_cfg(REG_KEY1, '0);
		write_cfg(REG_KEY2, '1);
		write_cfg(REG_KEY3, 64'h0123_4567_89AB_CDEF);
		write_cfg(REG_NONCE, '1);
		write_cfg(REG_START, '1);
		write_cfg(REG_ROUNDS, 64'(ROUNDS_8));
		for (int i = 0; i < 3; i++) send_word('1, 1'b1);
		drain();
		write_cfg(REG_SHORT, 64'd1);
		write_cfg(REG_ROUNDS, 64'd3);
		for (int i = 0; i < 3; i++) send_word(32'h8000_0001, 1'b1);
		drain();
		// Random part in idling phases, reprogrammed between phases.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin src_idle = 0; sink_stall = 0; end
				1: begin src_idle = 85; sink_stall = 0; end
				2: begin src_idle = 0; sink_stall = 85; end
				default: begin src_idle = 22; sink_stall = 22; end
			endcase
			setup_random();
			for (int i = 0; i < 160; i++) begin
				if (i == 80) begin
					drain();
					write_cfg(REG_ROUNDS, 64'($urandom_range(3)));
				end
				send_word($urandom(), $urandom_range(3) != 0);
			end
			drain();
		end
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_salsa20_keystream_cipher: PASS");
		else
			$display("tb_salsa20_keystream_cipher: FAIL");
		$finish;
	end
endmodule
